// ----- hdl/priority_ready_queue_scheduler_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the ready-queue scheduler
// Each macro expands to one labeled concurrent assertion clocked on clk and
// disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_READY_QUEUE_SCHEDULER_MACROS_SVH
`define PRIORITY_READY_QUEUE_SCHEDULER_MACROS_SVH

// Check a condition in the same cycle as its trigger
`define PRQS_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a condition in the cycle after its trigger
`define PRQS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/prqs_pkg.sv -----
// ----------------------------------------------------------------------------
// prqs_pkg
// Types, codes and default sizes shared by the ready-queue scheduler files.
// ----------------------------------------------------------------------------
`default_nettype none

package prqs_pkg;

  // Default sizes
  localparam int DEF_THREADS         = 8;
  localparam int DEF_PRIORITY_LEVELS = 16;

  // Request codes
  typedef enum logic [1:0] {
    REQ_REMOVE   = 2'd0,
    REQ_INSERT   = 2'd1,
    REQ_SCHEDULE = 2'd2,
    REQ_SET_PRIO = 2'd3
  } req_kind_t;

  // Response status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_SAME  = 2'd1,
    ST_NONE  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_READ  = 2'd1,
    S_QUEUE = 2'd2
  } state_t;

  // Request item
  typedef struct packed {
    req_kind_t  req_type;
    logic       thread_present;
    logic [2:0] thread_id;
    logic [3:0] new_priority;
  } req_t;

  // Response item
  typedef struct packed {
    status_t    status;
    logic [2:0] chosen_thread;
    logic [3:0] old_priority;
  } rsp_t;

endpackage

`default_nettype wire

// ----- hdl/priority_ready_queue_scheduler.sv -----
// ----------------------------------------------------------------------------
// priority_ready_queue_scheduler
// Thread ready queue with one FIFO per priority level, kept in RAM.
// ----------------------------------------------------------------------------
// Serves one request at a time and returns one response item per request.
// Schedule, set-priority and any refused request go from accept through S_READ
// to the response; a remove or insert that changes a queue also passes S_QUEUE,
// as set by the chain of RAM reads: thread tables first, then the queue table at
// the thread's level, then the write-back. Each thread's priority and link share
// one word of a thread RAM, and queue head/tail pairs sit in a second RAM,
// both with registered read data; per-entry valid bits in flip-flops give
// the reset values, so no clearing pass runs after reset. A new request is
// taken while the previous response waits only once the response register
// frees up in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_ready_queue_scheduler #(
  parameter int THREADS         = prqs_pkg::DEF_THREADS,
  parameter int PRIORITY_LEVELS = prqs_pkg::DEF_PRIORITY_LEVELS
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire prqs_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output prqs_pkg::rsp_t     rsp
);

  localparam int TW = $clog2(THREADS);
  localparam int PW = $clog2(PRIORITY_LEVELS);

  // Control state
  prqs_pkg::state_t           state, state_next;
  logic [THREADS-1:0]         ready_mark;
  logic [THREADS-1:0]         link_ok;
  logic [THREADS-1:0]         link_ok_next;
  logic [THREADS-1:0]         prio_ok;
  logic [PRIORITY_LEVELS-1:0] head_ok;
  logic [PRIORITY_LEVELS-1:0] tail_ok;

  // Payload registers
  prqs_pkg::req_t cur;
  logic [TW-1:0]  tidx;
  logic [PW-1:0]  level;
  logic           keep_link_ok;
  logic [TW-1:0]  keep_link;

  // Datapath signals
  logic                       accept;
  logic                       fin;
  prqs_pkg::rsp_t             rsp_next;
  logic                       named;
  logic [PW-1:0]              prio_val;
  logic [PW-1:0]              prio_sat;
  logic [PRIORITY_LEVELS-1:0] lowest;
  logic [PW-1:0]              best_level;
  logic [TW-1:0]              q_head;
  logic [TW-1:0]              q_tail;
  logic                       go_queue;

  // Update flags
  logic rdy_set, rdy_clr, lok_clr, lok_set;
  logic hd_set, hd_clr, tl_set, tl_clr;

  // RAM ports
  logic             prio_we;
  logic [PW-1:0]    prio_rdata;
  logic             link_we;
  logic [TW-1:0]    link_rdata;
  logic             thr_we;
  logic [TW-1:0]    thr_waddr;
  logic [PW+TW-1:0] thr_wdata;
  logic [PW+TW-1:0] thr_rdata;
  logic             q_re;
  logic [PW-1:0]    q_raddr;
  logic             q_we;
  logic [2*TW-1:0]  q_wdata;
  logic [2*TW-1:0]  q_rdata;

  // Thread word write: a new priority keeps the stored link; a link update at
  // the old tail keeps its priority, which equals the level since a queued
  // thread cannot change priority
  assign thr_we     = prio_we || link_we;
  assign thr_waddr  = link_we ? q_tail : tidx;
  assign thr_wdata  = link_we ? {level, tidx} : {prio_sat, link_rdata};
  assign prio_rdata = thr_rdata[PW+TW-1:TW];
  assign link_rdata = thr_rdata[TW-1:0];

  prqs_ram #(.WIDTH(PW + TW), .DEPTH(THREADS)) u_thread_ram (
    .clk   (clk),
    .we    (thr_we),
    .waddr (thr_waddr),
    .wdata (thr_wdata),
    .re    (accept),
    .raddr (TW'(req.thread_id)),
    .rdata (thr_rdata)
  );

  prqs_ram #(.WIDTH(2 * TW), .DEPTH(PRIORITY_LEVELS)) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (level),
    .wdata (q_wdata),
    .re    (q_re),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  // Find the lowest-numbered non-empty level: isolate lowest set bit, encode
  always_comb begin
    lowest     = head_ok & (~head_ok + PRIORITY_LEVELS'(1));
    best_level = '0;
    for (int i = 0; i < PRIORITY_LEVELS; i++) begin
      if (lowest[i]) begin
        best_level = best_level | PW'(i);
      end
    end
  end

  // Decode the captured request
  assign named    = cur.thread_present && ({29'd0, cur.thread_id} < 32'(THREADS));
  assign prio_val = prio_ok[tidx] ? prio_rdata : '0;
  assign prio_sat = ({28'd0, cur.new_priority} >= 32'(PRIORITY_LEVELS))
                  ? PW'(PRIORITY_LEVELS - 1) : PW'(cur.new_priority);
  assign q_head   = q_rdata[2*TW-1:TW];
  assign q_tail   = q_rdata[TW-1:0];

  // Sequencer: next state, RAM controls, response
  always_comb begin
    state_next = state;
    req_ready  = (state == prqs_pkg::S_IDLE) && (!rsp_valid || rsp_ready);
    accept     = req_valid && req_ready;
    fin        = 1'b0;
    rsp_next   = '0;
    go_queue   = 1'b0;
    prio_we    = 1'b0;
    link_we    = 1'b0;
    q_re       = 1'b0;
    q_raddr    = best_level;
    q_we       = 1'b0;
    q_wdata    = q_rdata;
    rdy_set    = 1'b0;
    rdy_clr    = 1'b0;
    lok_clr    = 1'b0;
    lok_set    = 1'b0;
    hd_set     = 1'b0;
    hd_clr     = 1'b0;
    tl_set     = 1'b0;
    tl_clr     = 1'b0;

    unique case (state)
      prqs_pkg::S_IDLE: begin
        // Schedule reads the best queue right away
        if (accept) begin
          q_re       = (req.req_type == prqs_pkg::REQ_SCHEDULE);
          state_next = prqs_pkg::S_READ;
        end
      end

      prqs_pkg::S_READ: begin
        unique case (cur.req_type)
          prqs_pkg::REQ_SCHEDULE: begin
            fin = 1'b1;
            if (|head_ok) begin
              rsp_next.status        = prqs_pkg::ST_DONE;
              rsp_next.chosen_thread = 3'(q_head);
            end else begin
              rsp_next.status = prqs_pkg::ST_EMPTY;
            end
          end
          prqs_pkg::REQ_SET_PRIO: begin
            fin = 1'b1;
            if (!named) begin
              rsp_next.status = prqs_pkg::ST_NONE;
            end else begin
              rsp_next.old_priority = 4'(prio_val);
              if (ready_mark[tidx]) begin
                rsp_next.status = prqs_pkg::ST_SAME;
              end else begin
                rsp_next.status = prqs_pkg::ST_DONE;
                prio_we         = 1'b1;
              end
            end
          end
          prqs_pkg::REQ_REMOVE: begin
            if (!named) begin
              fin             = 1'b1;
              rsp_next.status = prqs_pkg::ST_NONE;
            end else if (!ready_mark[tidx]) begin
              fin             = 1'b1;
              rsp_next.status = prqs_pkg::ST_SAME;
            end else begin
              go_queue = 1'b1;
            end
          end
          prqs_pkg::REQ_INSERT: begin
            if (!named) begin
              fin             = 1'b1;
              rsp_next.status = prqs_pkg::ST_NONE;
            end else if (ready_mark[tidx]) begin
              fin             = 1'b1;
              rsp_next.status = prqs_pkg::ST_SAME;
            end else begin
              go_queue = 1'b1;
            end
          end
          default: begin
            fin = 1'b1;
          end
        endcase
        // Read the queue at the thread's level
        if (go_queue) begin
          q_re       = 1'b1;
          q_raddr    = prio_val;
          state_next = prqs_pkg::S_QUEUE;
        end else begin
          state_next = prqs_pkg::S_IDLE;
        end
      end

      prqs_pkg::S_QUEUE: begin
        fin             = 1'b1;
        rsp_next.status = prqs_pkg::ST_DONE;
        state_next      = prqs_pkg::S_IDLE;
        if (cur.req_type == prqs_pkg::REQ_REMOVE) begin
          // Head takes the removed thread's link; a null link empties the queue
          rdy_clr = 1'b1;
          lok_clr = 1'b1;
          if (keep_link_ok) begin
            q_we    = 1'b1;
            q_wdata = {keep_link, q_tail};
            hd_set  = 1'b1;
          end else begin
            hd_clr = 1'b1;
            tl_clr = 1'b1;
          end
        end else begin
          // Append at the tail, or start the queue
          rdy_set = 1'b1;
          lok_clr = 1'b1;
          tl_set  = 1'b1;
          q_we    = 1'b1;
          if (tail_ok[level]) begin
            link_we = 1'b1;
            lok_set = 1'b1;
            q_wdata = {q_head, tidx};
          end else begin
            hd_set  = 1'b1;
            q_wdata = {tidx, tidx};
          end
        end
      end

      default: begin
        state_next = prqs_pkg::S_IDLE;
      end
    endcase
  end

  // Clear own link before linking from the old tail (tail may be itself)
  always_comb begin
    link_ok_next = link_ok;
    if (lok_clr) link_ok_next[tidx] = 1'b0;
    if (lok_set) link_ok_next[q_tail] = 1'b1;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= prqs_pkg::S_IDLE;
      rsp_valid  <= 1'b0;
      ready_mark <= '0;
      link_ok    <= '0;
      prio_ok    <= '0;
      head_ok    <= '0;
      tail_ok    <= '0;
    end else begin
      state <= state_next;
      if (fin) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (rdy_set) ready_mark[tidx] <= 1'b1;
      if (rdy_clr) ready_mark[tidx] <= 1'b0;
      link_ok <= link_ok_next;
      if (prio_we) prio_ok[tidx] <= 1'b1;
      if (hd_set) head_ok[level] <= 1'b1;
      if (hd_clr) head_ok[level] <= 1'b0;
      if (tl_set) tail_ok[level] <= 1'b1;
      if (tl_clr) tail_ok[level] <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cur  <= req;
      tidx <= TW'(req.thread_id);
    end
    if (go_queue) begin
      level        <= prio_val;
      keep_link_ok <= link_ok[tidx];
      keep_link    <= link_rdata;
    end
    if (fin) begin
      rsp <= rsp_next;
    end
  end

  `include "priority_ready_queue_scheduler_macros.svh"

  `PRQS_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready,
    "second item accepted while one is in flight")
  `PRQS_ASSERT_NEXT(a_sched_found,
    state == prqs_pkg::S_READ && cur.req_type == prqs_pkg::REQ_SCHEDULE && (|head_ok),
    rsp_valid && rsp.status == prqs_pkg::ST_DONE,
    "schedule missed a non-empty queue")
  `PRQS_ASSERT_NEXT(a_insert_fills,
    state == prqs_pkg::S_QUEUE && cur.req_type == prqs_pkg::REQ_INSERT,
    head_ok[level] && tail_ok[level],
    "insert left its queue without head or tail")

endmodule

`default_nettype wire

// ----- hdl/prqs_ram.sv -----
// ----------------------------------------------------------------------------
// prqs_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module prqs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- sim/priority_ready_queue_scheduler_test.sv -----
// ----------------------------------------------------------------------------
// priority_ready_queue_scheduler_test
// Self-checking bench for the thread ready-queue scheduler. A local model of
// the thread and queue tables predicts every response item. Directed requests
// cover reset state, queue order and refusals, then random request traffic
// runs with idle bursts on both channels and ends with a back-to-back stretch.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_ready_queue_scheduler_test;

  localparam int NTHR     = prqs_pkg::DEF_THREADS;
  localparam int NLEV     = prqs_pkg::DEF_PRIORITY_LEVELS;
  localparam logic [3:0] NIL_LINK = 4'(NTHR);
  localparam int RUN_LIMIT   = 3000000;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  prqs_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  prqs_pkg::rsp_t rsp;

  // Model of the thread and queue tables
  logic       thr_ready [NTHR];
  logic [3:0] thr_prio  [NTHR];
  logic [3:0] thr_link  [NTHR];
  logic [3:0] lvl_head  [NLEV];
  logic [3:0] lvl_tail  [NLEV];

  prqs_pkg::rsp_t pending_rsp [$];
  int   mismatches = 0;
  bit   idle_on    = 1'b1;
  bit   quiet_tail = 1'b0;
  int   stall_left = 0;

  priority_ready_queue_scheduler dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #5 clk = ~clk;

  initial begin
    for (int i = 0; i < NTHR; i++) begin
      thr_ready[i] = 1'b0;
      thr_prio[i]  = '0;
      thr_link[i]  = NIL_LINK;
    end
    for (int i = 0; i < NLEV; i++) begin
      lvl_head[i] = NIL_LINK;
      lvl_tail[i] = NIL_LINK;
    end
  end

  // Serve one request against the model and return its response item
  function automatic prqs_pkg::rsp_t predict_response(input prqs_pkg::req_t item);
    prqs_pkg::rsp_t r;
    int         t;
    int         lv;
    logic [3:0] tl;
    r  = '0;
    t  = item.thread_id;
    lv = thr_prio[t];
    if (item.req_type == prqs_pkg::REQ_SCHEDULE) begin
      r.status = prqs_pkg::ST_EMPTY;
      for (int i = 0; i < NLEV; i++) begin
        if (r.status == prqs_pkg::ST_EMPTY && lvl_head[i] < NIL_LINK) begin
          r.status        = prqs_pkg::ST_DONE;
          r.chosen_thread = lvl_head[i][2:0];
        end
      end
    end else if (!item.thread_present) begin
      r.status = prqs_pkg::ST_NONE;
    end else if (item.req_type == prqs_pkg::REQ_REMOVE) begin
      if (!thr_ready[t]) begin
        r.status = prqs_pkg::ST_SAME;
      end else begin
        // The head takes the removed thread's link even when it was not at the head
        lvl_head[lv] = thr_link[t];
        if (lvl_head[lv] >= NIL_LINK) begin
          lvl_head[lv] = NIL_LINK;
          lvl_tail[lv] = NIL_LINK;
        end
        thr_ready[t] = 1'b0;
        thr_link[t]  = NIL_LINK;
        r.status     = prqs_pkg::ST_DONE;
      end
    end else if (item.req_type == prqs_pkg::REQ_INSERT) begin
      if (thr_ready[t]) begin
        r.status = prqs_pkg::ST_SAME;
      end else begin
        thr_link[t] = NIL_LINK;
        tl = lvl_tail[lv];
        if (tl < NIL_LINK) thr_link[tl[2:0]] = 4'(t);
        else lvl_head[lv] = 4'(t);
        lvl_tail[lv] = 4'(t);
        thr_ready[t] = 1'b1;
        r.status     = prqs_pkg::ST_DONE;
      end
    end else begin
      r.old_priority = thr_prio[t];
      if (thr_ready[t]) begin
        r.status = prqs_pkg::ST_SAME;
      end else begin
        thr_prio[t] = item.new_priority;
        r.status    = prqs_pkg::ST_DONE;
      end
    end
    return r;
  endfunction

  function automatic prqs_pkg::req_t make_req(input prqs_pkg::req_kind_t kind,
                                              input logic present,
                                              input int id, input int prio);
    prqs_pkg::req_t item;
    item.req_type       = kind;
    item.thread_present = present;
    item.thread_id      = 3'(id);
    item.new_priority   = 4'(prio);
    return item;
  endfunction

  // Offer one item, hold it until accepted, then record its expected response.
  // Valid stays high on return so the next item can follow without a gap.
  task automatic send_request(input prqs_pkg::req_t item);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (!req_ready);
    pending_rsp.push_back(predict_response(item));
  endtask

  // Drop valid and wait out every outstanding response
  task automatic drain;
    req_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Response side: random stall bursts while idling is enabled
  always @(posedge clk) begin
    if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0)
      stall_left = $urandom_range(1, 13);
    if (stall_left != 0) begin
      stall_left--;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  task automatic report_field(input string name, input int exp_val, input int act_val);
    mismatches++;
    $display("%0t: %s expected %0d actual %0d", $time, name, exp_val, act_val);
  endtask

  // Compare each accepted response with the oldest expectation
  always @(posedge clk) begin
    prqs_pkg::rsp_t exp_rsp;
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_rsp.size() == 0) begin
        report_field("unexpected response, status", -1, rsp.status);
      end else begin
        exp_rsp = pending_rsp.pop_front();
        if (rsp.status !== exp_rsp.status)
          report_field("status", exp_rsp.status, rsp.status);
        if (rsp.chosen_thread !== exp_rsp.chosen_thread)
          report_field("chosen_thread", exp_rsp.chosen_thread, rsp.chosen_thread);
        if (rsp.old_priority !== exp_rsp.old_priority)
          report_field("old_priority", exp_rsp.old_priority, rsp.old_priority);
      end
    end
  end

  // Empty tables: nothing ready, absent thread, remove of an idle thread
  task automatic test_reset_state;
    send_request(make_req(prqs_pkg::REQ_SCHEDULE, 1'b0, 0, 0));
    send_request(make_req(prqs_pkg::REQ_REMOVE,   1'b1, 0, 0));
    send_request(make_req(prqs_pkg::REQ_REMOVE,   1'b0, 7, 15));
    send_request(make_req(prqs_pkg::REQ_INSERT,   1'b0, 3, 0));
    send_request(make_req(prqs_pkg::REQ_SET_PRIO, 1'b0, 5, 9));
    drain();
  endtask

  // FIFO order across levels, refusals on queued threads, non-head remove
  task automatic test_queue_order;
    send_request(make_req(prqs_pkg::REQ_SET_PRIO, 1'b1, 3, 15));
    send_request(make_req(prqs_pkg::REQ_SET_PRIO, 1'b1, 5, 15));
    send_request(make_req(prqs_pkg::REQ_SET_PRIO, 1'b1, 7, 0));
    send_request(make_req(prqs_pkg::REQ_INSERT,   1'b1, 3, 0));
    send_request(make_req(prqs_pkg::REQ_INSERT,   1'b1, 5, 0));
    send_request(make_req(prqs_pkg::REQ_INSERT,   1'b1, 7, 0));
    send_request(make_req(prqs_pkg::REQ_INSERT,   1'b1, 0, 0));
    send_request(make_req(prqs_pkg::REQ_SCHEDULE, 1'b1, 2, 4));
    send_request(make_req(prqs_pkg::REQ_REMOVE,   1'b1, 7, 0));
    send_request(make_req(prqs_pkg::REQ_SCHEDULE, 1'b0, 0, 0));
    send_request(make_req(prqs_pkg::REQ_REMOVE,   1'b1, 0, 0));
    send_request(make_req(prqs_pkg::REQ_SCHEDULE, 1'b1, 7, 15));
    send_request(make_req(prqs_pkg::REQ_INSERT,   1'b1, 3, 0));
    send_request(make_req(prqs_pkg::REQ_SET_PRIO, 1'b1, 3, 2));
    send_request(make_req(prqs_pkg::REQ_REMOVE,   1'b1, 5, 0));
    send_request(make_req(prqs_pkg::REQ_SCHEDULE, 1'b1, 0, 0));
    send_request(make_req(prqs_pkg::REQ_REMOVE,   1'b1, 3, 0));
    send_request(make_req(prqs_pkg::REQ_SET_PRIO, 1'b1, 3, 0));
    send_request(make_req(prqs_pkg::REQ_SCHEDULE, 1'b1, 0, 0));
    drain();
  endtask

  // Mostly well-formed traffic with random content, some noise
  task automatic test_random_traffic(input int count);
    prqs_pkg::req_t item;
    int   pick;
    int   lv;
    for (int n = 0; n < count; n++) begin
      if (!quiet_tail && n % 200 == 0) idle_on = ($urandom_range(0, 3) != 0);
      item.req_type       = prqs_pkg::req_kind_t'($urandom_range(0, 3));
      item.thread_present = ($urandom_range(0, 19) != 0);
      item.thread_id      = 3'($urandom_range(0, NTHR - 1));
      item.new_priority   = 4'($urandom_range(0, 15));
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        item.req_type = prqs_pkg::REQ_INSERT;
      end else if (pick < 55) begin
        item.req_type = prqs_pkg::REQ_REMOVE;
        // Prefer a queue head so the queues stay well formed
        if ($urandom_range(0, 4) != 0) begin
          lv = $urandom_range(0, NLEV - 1);
          for (int i = 0; i < NLEV; i++) begin
            if (lvl_head[(lv + i) % NLEV] < NIL_LINK && thr_ready[lvl_head[(lv + i) % NLEV]]) begin
              item.thread_id = lvl_head[(lv + i) % NLEV][2:0];
              break;
            end
          end
        end
      end else if (pick < 75) begin
        item.req_type = prqs_pkg::REQ_SCHEDULE;
      end else begin
        item.req_type = prqs_pkg::REQ_SET_PRIO;
        if ($urandom_range(0, 9) < 7) item.new_priority = 4'($urandom_range(0, 3));
        // Prefer an idle thread so most priority changes take effect
        if ($urandom_range(0, 3) != 0) begin
          for (int i = 0; i < 8 && thr_ready[item.thread_id]; i++)
            item.thread_id = 3'($urandom_range(0, NTHR - 1));
        end
      end
      send_request(item);
    end
    drain();
  endtask

  // Closing stretch with no idling on either side
  task automatic test_back_to_back(input int count);
    quiet_tail = 1'b1;
    idle_on    = 1'b0;
    test_random_traffic(count);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_queue_order();
    test_random_traffic(1800);
    test_back_to_back(200);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #(RUN_LIMIT);
    $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+hdl
hdl/prqs_pkg.sv
hdl/prqs_ram.sv
hdl/priority_ready_queue_scheduler.sv
sim/priority_ready_queue_scheduler_test.sv
